/* rtl/u8sd_pkg.sv */
package u8sd_pkg;

  // Width of the accumulated character value; code_point shows its low 32 bits.
  localparam int CODE_WIDTH = 32;
  localparam int CP_WIDTH   = 32;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADCONT = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_NUL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [CP_WIDTH-1:0] code_point;
    logic [3:0]          seq_length;
    status_t             status;
  } result_t;

endpackage

/* rtl/u8sd_if.sv */
interface u8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface u8sd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_point;
  logic [3:0]  seq_length;
  logic [1:0]  status;

  modport source (output valid, output code_point, output seq_length, output status,
                  input ready);
  modport sink   (input valid, input code_point, input seq_length, input status,
                  output ready);
endinterface

/* rtl/u8sd_in_reg.sv */
module u8sd_in_reg (
  input  logic           clk,
  input  logic           rst,
  u8sd_in_if.sink        stream,
  input  logic           take,
  output logic           item_valid,
  output u8sd_pkg::item_t item
);
  import u8sd_pkg::*;

  logic  full;
  item_t held;

  // Refill whenever the held request leaves or the register is empty.
  assign stream.ready = !full || take;
  assign item_valid   = full;
  assign item         = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      held.in_byte   <= stream.in_byte;
      held.last_byte <= stream.last_byte;
    end
  end

endmodule

/* rtl/u8sd_decode.sv */
module u8sd_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  u8sd_pkg::item_t  item,
  output logic             has_result,
  output u8sd_pkg::result_t result
);
  import u8sd_pkg::*;

  logic [CODE_WIDTH-1:0] partial_value, partial_value_next;
  logic [2:0]            bytes_remaining, bytes_remaining_next;
  logic [3:0]            sequence_length, sequence_length_next;
  logic [3:0]            lead_len;
  logic [7:0]            lead_mask;
  logic [CODE_WIDTH-1:0] shifted;

  always_comb begin
    case (item.in_byte) inside
      8'b0???????: lead_len = 4'd1;
      8'b10??????: lead_len = 4'd1;
      8'b110?????: lead_len = 4'd2;
      8'b1110????: lead_len = 4'd3;
      8'b11110???: lead_len = 4'd4;
      8'b111110??: lead_len = 4'd5;
      8'b1111110?: lead_len = 4'd6;
      8'b11111110: lead_len = 4'd7;
      default:     lead_len = 4'd8;
    endcase
  end

  assign lead_mask = 8'hFF >> lead_len;
  assign shifted   = {partial_value[CODE_WIDTH-7:0], item.in_byte[5:0]};

  always_comb begin
    partial_value_next   = partial_value;
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    has_result           = 1'b0;
    result.code_point    = '0;
    result.seq_length    = 4'd0;
    result.status        = ST_OK;

    if (bytes_remaining == 3'd0) begin
      if (!item.in_byte[7]) begin
        has_result = 1'b1;
        if (item.in_byte == 8'h00) begin
          result.status = ST_NUL;
        end else begin
          result.code_point = CP_WIDTH'(item.in_byte);
          result.seq_length = 4'd1;
        end
      end else if (lead_len == 4'd1) begin
        // Stray continuation byte taken as a one-byte character.
        has_result        = 1'b1;
        result.code_point = CP_WIDTH'(item.in_byte[6:0]);
        result.seq_length = 4'd1;
      end else if (item.last_byte) begin
        has_result    = 1'b1;
        result.status = ST_TRUNC;
      end else begin
        partial_value_next   = CODE_WIDTH'(item.in_byte & lead_mask);
        bytes_remaining_next = 3'(lead_len - 4'd1);
        sequence_length_next = lead_len;
      end
    end else if (item.last_byte && bytes_remaining > 3'd1) begin
      has_result           = 1'b1;
      result.status        = ST_TRUNC;
      partial_value_next   = '0;
      bytes_remaining_next = 3'd0;
      sequence_length_next = 4'd0;
    end else if (item.in_byte[7:6] != 2'b10) begin
      // Drop the offending byte and return to idle.
      has_result           = 1'b1;
      result.status        = ST_BADCONT;
      partial_value_next   = '0;
      bytes_remaining_next = 3'd0;
      sequence_length_next = 4'd0;
    end else if (bytes_remaining == 3'd1) begin
      has_result           = 1'b1;
      result.code_point    = CP_WIDTH'(shifted);
      result.seq_length    = sequence_length;
      partial_value_next   = '0;
      bytes_remaining_next = 3'd0;
      sequence_length_next = 4'd0;
    end else begin
      partial_value_next   = shifted;
      bytes_remaining_next = bytes_remaining - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_remaining <= 3'd0;
      sequence_length <= 4'd0;
    end else if (take) begin
      partial_value   <= partial_value_next;
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
    end
  end

endmodule

/* rtl/u8sd_out_reg.sv */
module u8sd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  u8sd_pkg::result_t result,
  u8sd_out_if.source        chars,
  output logic              free
);
  import u8sd_pkg::*;

  logic    full;
  result_t held;

  assign free             = !full || chars.ready;
  assign chars.valid      = full;
  assign chars.code_point = held.code_point;
  assign chars.seq_length = held.seq_length;
  assign chars.status     = held.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (chars.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

/* rtl/utf8_stream_decoder_unit.sv */
// UTF-8 stream decoder, extended form (sequences of 2 to 8 bytes).
// stream: one request per byte, carrying in_byte and last_byte (final byte of a
//   buffer). A byte is taken on a rising edge with valid and ready both high.
// chars: one request per finished character or error: code_point, seq_length
//   and status (ok, bad continuation, truncated, nul byte).
// Lead bytes and middle continuation bytes produce no request on chars unless they carry last_byte.
// Path: a byte that completes a character is decoded combinationally from the
//   input register, and its result is loaded into the output register once that
//   register can absorb it; its request is valid on chars from that load.
// Throughput: one byte per cycle, sustained, with chars.ready held high; the
//   decode of each byte is one short pass between the two registers.
// Stall: while chars holds an untaken request, the input register drains only
//   when chars.ready is high; stream.ready then drops once the input register
//   is also full, so no byte or result is lost.
// Reset: rst (synchronous) empties both registers and returns the decoder to
//   idle, awaiting a lead byte.
module utf8_stream_decoder_unit (
  input  logic clk,
  input  logic rst,
  u8sd_in_if.sink    stream,
  u8sd_out_if.source chars
);
  import u8sd_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    out_free;
  logic    take;
  logic    has_result;
  result_t result;

  // Advance the held byte whenever the result register can absorb its outcome.
  assign take = item_valid && out_free;

  u8sd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  u8sd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .item       (item),
    .has_result (has_result),
    .result     (result)
  );

  u8sd_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (take && has_result),
    .result (result),
    .chars  (chars),
    .free   (out_free)
  );

endmodule

/* tb/sv/u8sd_tb_pkg.sv */
`timescale 1ns / 100ps

package u8sd_tb_pkg;
  import u8sd_pkg::*;

  // Tracks decoder state per accepted byte and holds the characters still owed.
  class char_scoreboard;
    logic [CODE_WIDTH-1:0] partial;
    logic [2:0]            remaining;
    logic [3:0]            seq_len;
    result_t               expected_chars[$];
    int unsigned           mismatches;
    int unsigned           bytes_noted;
    int unsigned           status_seen[4];

    function new();
      return_to_idle();
      mismatches  = 0;
      bytes_noted = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void return_to_idle();
      partial   = '0;
      remaining = '0;
      seq_len   = '0;
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Advance the decoder by one accepted byte; queue a character if one is due.
    function void note_byte(input logic [7:0] b, input logic last);
      result_t     r;
      int unsigned ones;
      ones         = 1;
      r.code_point = '0;
      r.seq_length = '0;
      r.status     = ST_OK;
      bytes_noted++;
      if (remaining == 0) begin
        if (!b[7]) begin
          r.code_point = CP_WIDTH'(b);
          r.seq_length = (b == 8'h00) ? 4'd0 : 4'd1;
          r.status     = (b == 8'h00) ? ST_NUL : ST_OK;
          expected_chars.push_back(r);
          return;
        end
        while (ones < 8 && b[7 - ones]) ones++;
        if (ones == 1) begin
          // lone continuation byte stands for itself, top bit dropped
          r.code_point = CP_WIDTH'(b & 8'h7F);
          r.seq_length = 4'd1;
          expected_chars.push_back(r);
        end else if (last) begin
          return_to_idle();
          r.status = ST_TRUNC;
          expected_chars.push_back(r);
        end else begin
          partial   = CODE_WIDTH'(b & (8'hFF >> (ones + 1)));
          remaining = 3'(ones - 1);
          seq_len   = 4'(ones);
        end
        return;
      end
      if (last && remaining > 1) begin
        return_to_idle();
        r.status = ST_TRUNC;
        expected_chars.push_back(r);
      end else if (b[7:6] != 2'b10) begin
        return_to_idle();
        r.status = ST_BADCONT;
        expected_chars.push_back(r);
      end else begin
        // high bits fall off the accumulator
        partial   = CODE_WIDTH'({partial, b[5:0]});
        remaining = remaining - 3'd1;
        if (remaining == 0) begin
          r.code_point = CP_WIDTH'(partial);
          r.seq_length = seq_len;
          expected_chars.push_back(r);
          return_to_idle();
        end
      end
    endfunction

    task check_char(input logic [CP_WIDTH-1:0] cp, input logic [3:0] len,
                    input logic [1:0] st);
      result_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("char with none owed: cp=%h len=%0d status=%0d",
                                  cp, len, st));
        return;
      end
      want = expected_chars.pop_front();
      status_seen[want.status]++;
      if (cp !== want.code_point)
        report_mismatch($sformatf("code_point %h, want %h", cp, want.code_point));
      if (len !== want.seq_length)
        report_mismatch($sformatf("seq_length %0d, want %0d", len, want.seq_length));
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %s", st, want.status.name()));
    endtask

    task check_leftovers();
      while (expected_chars.size() != 0) begin
        report_mismatch($sformatf("char never came: cp=%h len=%0d status=%s",
                                  expected_chars[0].code_point,
                                  expected_chars[0].seq_length,
                                  expected_chars[0].status.name()));
        void'(expected_chars.pop_front());
      end
    endtask
  endclass

endpackage

/* tb/sv/tb_utf8_stream_decoder_unit.sv */
`timescale 1ns / 100ps

module tb_utf8_stream_decoder_unit;
  import u8sd_pkg::*;
  import u8sd_tb_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Directed bytes: ASCII (with the last mark), NUL, a lone continuation, a
  // 2-byte char ending on the last mark, a 3-byte char, the 8-byte 0xFF lead
  // that overflows 32 bits, a lead carrying the last mark, a bad continuation,
  // a truncation mid-sequence and a NUL inside a sequence.
  localparam item_t DIRECTED [24] = '{
    {8'h41, 1'b0}, {8'h7F, 1'b1}, {8'h00, 1'b0}, {8'h80, 1'b0},
    {8'hC3, 1'b0}, {8'hA9, 1'b1},
    {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'hAC, 1'b0},
    {8'hFF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
    {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
    {8'hC3, 1'b1},
    {8'hE2, 1'b0}, {8'h41, 1'b0},
    {8'hF0, 1'b0}, {8'h9F, 1'b1},
    {8'hC3, 1'b0}, {8'h00, 1'b0}
  };

  logic clk;
  logic rst;
  logic hold_chars = 1'b0;
  idle_mode_t idle_mode = IDLE_NONE;
  int unsigned bytes_sent = 0;

  u8sd_in_if  stream_if ();
  u8sd_out_if chars_if ();

  char_scoreboard sb = new();

  utf8_stream_decoder_unit uut (
    .clk   (clk),
    .rst   (rst),
    .stream(stream_if),
    .chars (chars_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit roll_pct(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SENDER: return roll_pct(72);
      IDLE_BOTH:   return roll_pct(8);
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return roll_pct(72);
      IDLE_BOTH:     return roll_pct(8);
      default:       return 1'b0;
    endcase
  endfunction

  // Receiver: drive chars.ready each edge. A long hold-off overrides the
  // random stalls so the block backs up into the stream side.
  initial begin
    chars_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      chars_if.ready <= !hold_chars && !receiver_stall();
    end
  end

  // Observe both channels on the edge. Note the byte before checking chars so
  // that even a same-edge result would find its expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (stream_if.valid && stream_if.ready)
        sb.note_byte(stream_if.in_byte, stream_if.last_byte);
      if (chars_if.valid && chars_if.ready)
        sb.check_char(chars_if.code_point, chars_if.seq_length, chars_if.status);
    end
  end

  // Offer one byte and hold it until the request is taken. Valid stays high
  // across back-to-back requests; it drops only during sender gaps.
  task automatic send_byte(input logic [7:0] value, input logic last);
    while (sender_gap()) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid     <= 1'b1;
    stream_if.in_byte   <= value;
    stream_if.last_byte <= last;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid and wait until every owed character has arrived. Sample the
  // queue on the falling edge, away from the monitor's updates.
  task automatic drain_chars();
    stream_if.valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (sb.pending() == 0) break;
    end
    @(posedge clk);
  endtask

  // Mostly well-formed characters of 1 to 8 bytes with random payload; now and
  // then a corrupted continuation, a stray last mark or a fully random byte.
  task automatic send_random_sequence();
    int unsigned n;
    int unsigned k;
    int unsigned roll;
    logic [7:0]  b;
    roll = $urandom_range(99);
    if (roll < 10) begin
      send_byte(8'($urandom), roll_pct(30));
      return;
    end
    n = $urandom_range(1, 8);
    if (n == 1) begin
      roll = $urandom_range(99);
      if (roll < 10)      b = 8'h00;
      else if (roll < 25) b = {2'b10, 6'($urandom)};
      else                b = {1'b0, 7'($urandom)};
      send_byte(b, roll_pct(10));
      return;
    end
    // n leading ones, a zero below n = 8, then random payload (0xFE and 0xFF carry none)
    b = 8'(8'hFF << (8 - n)) | (8'($urandom) & (8'hFF >> (n + 1)));
    send_byte(b, roll_pct(4));
    for (k = 1; k < n; k++) begin
      b = {2'b10, 6'($urandom)};
      if (roll_pct(6)) b = 8'($urandom);
      send_byte(b, (k == n - 1) ? roll_pct(30) : roll_pct(3));
    end
  endtask

  task automatic run_phase(input idle_mode_t mode, input int unsigned count);
    int unsigned target;
    target = bytes_sent + count;
    idle_mode <= mode;
    while (bytes_sent < target) send_random_sequence();
    drain_chars();
  endtask

  initial begin
    int unsigned target;
    stream_if.valid     <= 1'b0;
    stream_if.in_byte   <= 8'h00;
    stream_if.last_byte <= 1'b0;
    rst                 <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed bytes, full rate
    foreach (DIRECTED[i]) send_byte(DIRECTED[i].in_byte, DIRECTED[i].last_byte);
    drain_chars();

    // random traffic under each idling pattern; pause for drain between them
    run_phase(IDLE_NONE, 110);
    run_phase(IDLE_SENDER, 110);
    run_phase(IDLE_RECEIVER, 110);
    run_phase(IDLE_BOTH, 110);

    // hold chars.ready low for a long stretch while bytes keep coming, so
    // both registers fill and the stream side stalls
    idle_mode <= IDLE_NONE;
    target = bytes_sent + 60;
    fork
      begin
        hold_chars <= 1'b1;
        repeat (150) @(posedge clk);
        hold_chars <= 1'b0;
      end
      begin
        while (bytes_sent < target) send_random_sequence();
      end
    join
    drain_chars();

    // allow for anything still in the two register stages
    repeat (8) @(posedge clk);
    sb.check_leftovers();

    $display("Run covered %0d bytes: directed cases, four idling patterns,", bytes_sent);
    $display("a long hold-off on chars and drain pauses; chars ok %0d, bad cont %0d, "
             , sb.status_seen[ST_OK], sb.status_seen[ST_BADCONT]);
    $display("truncated %0d, nul %0d, mismatches %0d",
             sb.status_seen[ST_TRUNC], sb.status_seen[ST_NUL], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d chars still owed", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
